// ----- design/iahp_pkg.sv -----
// Shared constants for the IIR allpass Hilbert pair.
// No dependencies; the interfaces refer to it, the top level and testbench import it.
package iahp_pkg;

  localparam int DEF_SAMPLE_BITS    = 24;
  localparam int DEF_COEF_FRAC_BITS = 22;

  // Allpass sections: real first, real second, imag first, imag second.
  localparam int NUM_SECTIONS = 4;
  // Multiplied taps per section (the unit x[n-2] tap is a shift).
  localparam int NUM_TAPS     = 4;
  localparam int HIST_ENTRIES = 4;

  // History entry layout within a section.
  localparam int HIST_X1 = 0;
  localparam int HIST_X2 = 1;
  localparam int HIST_Y1 = 2;
  localparam int HIST_Y2 = 3;

endpackage

// ----- design/iahp_in_if.sv -----
// Request channel carrying one input audio sample.
// Depends on iahp_pkg for the default sample width.
interface iahp_in_if #(
  parameter int SAMPLE_BITS = iahp_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- design/iahp_out_if.sv -----
// Request channel carrying one quadrature output pair.
// Depends on iahp_pkg for the default sample width.
interface iahp_out_if #(
  parameter int SAMPLE_BITS = iahp_pkg::DEF_SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] real_out;
  logic signed [SAMPLE_BITS-1:0] imag_out;

  modport source (output valid, output real_out, output imag_out, input ready);
  modport sink   (input valid, input real_out, input imag_out, output ready);
endinterface

// ----- design/iir_allpass_hilbert_pair_unit.sv -----
// IIR allpass Hilbert pair: top level with the shared multiply-accumulate sequencer.
// Depends on iahp_pkg, iahp_in_if and iahp_out_if.
//
//   channel   dir  payload                        request accepted when
//   samples   in   sample   (signed SAMPLE_BITS)  samples.valid && samples.ready
//   results   out  real_out, imag_out (signed)    results.valid && results.ready
//
// After the accept, one request runs 4 sections x 5 steps on the single shared
// multiplier (4 products per section, plus one step to add the last product,
// round, saturate and write history). samples.ready is high only when idle.
// rst is synchronous and clears all section histories to zero.
// A finished pair waits in a holding register while results stalls; the next
// sample is accepted as soon as the sequencer is idle, even with a result pending.
module iir_allpass_hilbert_pair_unit #(
  parameter int SAMPLE_BITS    = iahp_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS = iahp_pkg::DEF_COEF_FRAC_BITS
) (
  input logic      clk,
  input logic      rst,
  iahp_in_if.sink  samples,
  iahp_out_if.source results
);
  import iahp_pkg::*;

  // History is two bits wider than a sample; coefficients are signed Q2.F.
  localparam int HIST_W = SAMPLE_BITS + 2;
  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = HIST_W + COEF_W;
  // Five products plus rounding bias need three guard bits.
  localparam int ACC_W  = PROD_W + 3;
  localparam int SHR_W  = ACC_W - COEF_FRAC_BITS;
  localparam int SEC_W  = $clog2(NUM_SECTIONS);
  localparam int TAP_IW = $clog2(NUM_TAPS);
  localparam int TAP_W  = $clog2(NUM_TAPS + 1);
  localparam logic [TAP_W-1:0] TAP_FINISH = TAP_W'(NUM_TAPS);
  localparam logic [SEC_W-1:0] SEC_LAST   = SEC_W'(NUM_SECTIONS - 1);

  // Coefficient magnitudes, round(c * 2^F) with ties away from zero.
  localparam longint K0 = ((longint'(94657)  << COEF_FRAC_BITS) + 50000)  / 100000;
  localparam longint K1 = ((longint'(194632) << COEF_FRAC_BITS) + 50000)  / 100000;
  localparam longint K2 = ((longint'(6338)   << COEF_FRAC_BITS) + 50000)  / 100000;
  localparam longint K3 = ((longint'(83774)  << COEF_FRAC_BITS) + 50000)  / 100000;
  localparam longint K4 = ((longint'(260502) << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K5 = ((longint'(2569)   << COEF_FRAC_BITS) + 50000)  / 100000;
  localparam longint K6 = ((longint'(870686) << COEF_FRAC_BITS) + 500000) / 1000000;
  localparam longint K7 = ((longint'(18685)  << COEF_FRAC_BITS) + 5000)   / 10000;

  // Per section: x[n] (a), x[n-1] (b), y[n-1] (c), y[n-2] (d).
  localparam logic signed [COEF_W-1:0] COEF_TAB [NUM_SECTIONS*NUM_TAPS] = '{
    COEF_W'(K0),  COEF_W'(-K1), COEF_W'(K1),  COEF_W'(-K0),
    COEF_W'(K2),  COEF_W'(-K3), COEF_W'(K3),  COEF_W'(-K2),
    COEF_W'(-K4), COEF_W'(K5),  COEF_W'(-K5), COEF_W'(K4),
    COEF_W'(K6),  COEF_W'(-K7), COEF_W'(K7),  COEF_W'(-K6)
  };

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_HOLD} state_t;

  state_t                       state;
  logic [SEC_W-1:0]             sec;
  logic [TAP_W-1:0]             tap;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic signed [HIST_W-1:0]     xin;
  // hist[0] always belongs to the section being worked; the sets rotate.
  logic signed [HIST_W-1:0]     hist [NUM_SECTIONS][HIST_ENTRIES];
  logic signed [PROD_W-1:0]     prod;
  logic signed [ACC_W-1:0]      acc;
  logic signed [SAMPLE_BITS-1:0] re_res;
  logic signed [SAMPLE_BITS-1:0] im_res;
  logic signed [SAMPLE_BITS-1:0] out_real;
  logic signed [SAMPLE_BITS-1:0] out_imag;
  logic                         out_valid;

  logic signed [COEF_W-1:0]     coef;
  logic signed [HIST_W-1:0]     opnd;
  logic signed [ACC_W-1:0]      base;
  logic signed [ACC_W-1:0]      sum;
  logic signed [SHR_W-1:0]      shr;
  logic signed [HIST_W-1:0]     sec_out;
  logic signed [SAMPLE_BITS-1:0] sec_sat;
  logic                         out_free;
  logic                         out_load;

  assign coef = COEF_TAB[{sec, tap[TAP_IW-1:0]}];

  always_comb begin
    case (tap[TAP_IW-1:0])
      2'd0:    opnd = xin;
      2'd1:    opnd = hist[0][HIST_X1];
      2'd2:    opnd = hist[0][HIST_Y1];
      default: opnd = hist[0][HIST_Y2];
    endcase
  end

  // Unit tap on x[n-2] enters as a shift, together with the half-LSB bias.
  assign base = (ACC_W'(hist[0][HIST_X2]) <<< COEF_FRAC_BITS) + ROUND_BIAS;
  assign sum  = acc + ACC_W'(prod);
  assign shr  = sum[ACC_W-1:COEF_FRAC_BITS];

  // Section result saturates to history width.
  always_comb begin
    if (shr[SHR_W-1:HIST_W-1] != {(SHR_W-HIST_W+1){shr[SHR_W-1]}}) begin
      sec_out = {shr[SHR_W-1], {(HIST_W-1){~shr[SHR_W-1]}}};
    end else begin
      sec_out = shr[HIST_W-1:0];
    end
  end

  // Chain output clamps to sample width.
  always_comb begin
    if (sec_out[HIST_W-1:SAMPLE_BITS-1] != {(HIST_W-SAMPLE_BITS+1){sec_out[HIST_W-1]}}) begin
      sec_sat = {sec_out[HIST_W-1], {(SAMPLE_BITS-1){~sec_out[HIST_W-1]}}};
    end else begin
      sec_sat = sec_out[SAMPLE_BITS-1:0];
    end
  end

  assign out_free = !out_valid || results.ready;
  // A new pair enters the output register this cycle.
  assign out_load = out_free && ((state == ST_HOLD) ||
                    (state == ST_RUN && tap == TAP_FINISH && sec == SEC_LAST));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sec       <= '0;
      tap       <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < NUM_SECTIONS; s++) begin
        for (int e = 0; e < HIST_ENTRIES; e++) begin
          hist[s][e] <= '0;
        end
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            samp  <= samples.sample;
            xin   <= HIST_W'(samples.sample);
            sec   <= '0;
            tap   <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (tap != TAP_FINISH) begin
            prod <= PROD_W'(coef) * PROD_W'(opnd);
            acc  <= (tap == '0) ? base : sum;
            tap  <= tap + 1'b1;
          end else begin
            // Retire this section's history into the back of the rotation.
            for (int s = 0; s < NUM_SECTIONS - 1; s++) begin
              hist[s] <= hist[s+1];
            end
            hist[NUM_SECTIONS-1][HIST_X1] <= xin;
            hist[NUM_SECTIONS-1][HIST_X2] <= hist[0][HIST_X1];
            hist[NUM_SECTIONS-1][HIST_Y1] <= sec_out;
            hist[NUM_SECTIONS-1][HIST_Y2] <= hist[0][HIST_Y1];
            tap <= '0;
            sec <= sec + 1'b1;
            if (sec[0] == 1'b0) begin
              // first section of a chain feeds the second
              xin <= sec_out;
            end else if (sec != SEC_LAST) begin
              // real chain done; imag chain restarts from the sample
              re_res <= sec_sat;
              xin    <= HIST_W'(samp);
            end else begin
              im_res <= sec_sat;
              if (out_free) begin
                out_real  <= re_res;
                out_imag  <= sec_sat;
                state     <= ST_IDLE;
              end else begin
                state <= ST_HOLD;
              end
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_real  <= re_res;
            out_imag  <= im_res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign samples.ready    = (state == ST_IDLE);
  assign results.valid    = out_valid;
  assign results.real_out = out_real;
  assign results.imag_out = out_imag;

endmodule

// ----- dv/tb_iir_allpass_hilbert_pair_unit.sv -----
// Testbench for iir_allpass_hilbert_pair_unit: random and directed audio samples
// checked pair by pair against a fixed-point predictor of the four allpass sections.
// Depends on iahp_pkg, iahp_in_if, iahp_out_if and the design top level.
`timescale 1ns / 100ps

module tb_iir_allpass_hilbert_pair_unit;
  import iahp_pkg::*;

  localparam int SB         = DEF_SAMPLE_BITS;
  localparam int CFB        = DEF_COEF_FRAC_BITS;
  localparam int HB         = SB + 2;            // history width
  localparam int NUM_COEFS  = NUM_TAPS + 1;      // a, b, unit, c, d
  localparam int IDLE_LIMIT = 4000;              // cycles with no request accepted on either side
  localparam int N_RANDOM   = 1500;

  localparam longint S_MAX = (64'sd1 <<< (SB - 1)) - 1;
  localparam longint S_MIN = -(64'sd1 <<< (SB - 1));

  typedef struct {
    logic signed [SB-1:0] value;
    bit                   drain_first;   // hold off until no pair is outstanding
  } sample_req_t;

  typedef struct {
    logic signed [SB-1:0] re;
    logic signed [SB-1:0] im;
  } quad_pair_t;

  logic clk;
  logic rst;

  iahp_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  iahp_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  iir_allpass_hilbert_pair_unit #(
    .SAMPLE_BITS   (SB),
    .COEF_FRAC_BITS(CFB)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(in_ch),
    .results(out_ch)
  );

  // Pending stimulus and the pairs the predictor expects, oldest first.
  sample_req_t sample_queue[$];
  quad_pair_t  pair_queue[$];

  // Predictor state: one history per section, in package section order
  // (real first, real second, imag first, imag second). Starts at zero.
  longint sect_hist[NUM_SECTIONS][HIST_ENTRIES];
  longint sect_coef[NUM_SECTIONS][NUM_COEFS];

  int error_count     = 0;
  int samples_sent    = 0;
  int pairs_checked   = 0;
  int clipped_outputs = 0;
  int idle_cycles;

  // Driver burst/gap bookkeeping.
  int burst_left;
  int gap_left;

  // Receiver stall pattern.
  int stall_mode;
  int mode_timer;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Q2.CFB coefficient from a decimal fraction num/den, ties away from zero.
  function automatic longint coef_round(input longint num, input longint den);
    return ((num <<< CFB) + den / 2) / den;
  endfunction

  function automatic longint clamp_bits(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // y = a*x0 + b*x1 + x2 + c*y1 + d*y2, rounded half up, saturated to HB.
  // The saturated value goes back into the y history.
  function automatic longint allpass_section(input int sec, input longint x0);
    longint acc;
    longint r;
    acc = sect_coef[sec][0] * x0
        + sect_coef[sec][1] * sect_hist[sec][HIST_X1]
        + sect_coef[sec][2] * sect_hist[sec][HIST_X2]
        + sect_coef[sec][3] * sect_hist[sec][HIST_Y1]
        + sect_coef[sec][4] * sect_hist[sec][HIST_Y2]
        + (64'sd1 <<< (CFB - 1));
    r = clamp_bits(acc >>> CFB, HB);
    sect_hist[sec][HIST_X2] = sect_hist[sec][HIST_X1];
    sect_hist[sec][HIST_X1] = x0;
    sect_hist[sec][HIST_Y2] = sect_hist[sec][HIST_Y1];
    sect_hist[sec][HIST_Y1] = r;
    return r;
  endfunction

  // Runs one accepted sample through both chains and queues the expected pair.
  function automatic void hilbert_pair_predict(input logic signed [SB-1:0] s);
    longint     x;
    longint     re;
    longint     im;
    longint     re_sat;
    longint     im_sat;
    quad_pair_t p;
    x  = longint'(s);
    re = allpass_section(1, allpass_section(0, x));
    im = allpass_section(3, allpass_section(2, x));
    re_sat = clamp_bits(re, SB);
    im_sat = clamp_bits(im, SB);
    if (re_sat != re) clipped_outputs++;
    if (im_sat != im) clipped_outputs++;
    p.re = re_sat[SB-1:0];
    p.im = im_sat[SB-1:0];
    pair_queue.push_back(p);
  endfunction

  function automatic void queue_sample(input longint v, input bit drain);
    sample_req_t r;
    r.value       = v[SB-1:0];
    r.drain_first = drain;
    sample_queue.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. valid is held
  // while ready is low; a request flagged drain_first waits for an empty
  // pair queue.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap_left    <= 0;
      burst_left  <= 1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        hilbert_pair_predict(in_ch.sample);
        samples_sent++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left    <= gap_left - 1;
        end else if (sample_queue.size() > 0 &&
                     (!sample_queue[0].drain_first || pair_queue.size() == 0)) begin
          in_ch.valid  <= 1'b1;
          in_ch.sample <= sample_queue[0].value;
          void'(sample_queue.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            // Mostly short gaps so they land on every sequencer step; some long.
            gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                      : $urandom_range(0, 4);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: whenever its mode timer runs out, the receiver picks one of no stalls,
  // coin-flip stalls and long stall runs; each accepted pair is compared with the
  // oldest expected one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    quad_pair_t exp_pair;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_mode   <= 0;
      mode_timer   <= 0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pair_queue.size() == 0) begin
          $display("%0t: unexpected result real=%0d imag=%0d",
                   $time, out_ch.real_out, out_ch.imag_out);
          error_count++;
        end else begin
          exp_pair = pair_queue.pop_front();
          pairs_checked++;
          if (out_ch.real_out !== exp_pair.re) begin
            $display("%0t: real_out mismatch expected=%0d actual=%0d",
                     $time, exp_pair.re, out_ch.real_out);
            error_count++;
          end
          if (out_ch.imag_out !== exp_pair.im) begin
            $display("%0t: imag_out mismatch expected=%0d actual=%0d",
                     $time, exp_pair.im, out_ch.imag_out);
            error_count++;
          end
        end
      end

      if (mode_timer >= 200) begin
        mode_timer <= 0;
        stall_mode <= $urandom_range(0, 2);
      end else begin
        mode_timer <= mode_timer + 1;
      end

      case (stall_mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 40);
          end
        end
      endcase
    end
  end

  // Watchdog: cycles with no request accepted on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
      $display("tb_iir_allpass_hilbert_pair_unit: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int     kind;
    int     seg_len;
    int     period;
    int     shift;
    longint amp;
    longint v;
    logic [31:0] r32;

    rst = 1'b1;

    // Coefficient order per section: a (x0), b (x1), unit (x2), c (y1), d (y2).
    sect_coef[0] = '{ coef_round(94657, 100000), -coef_round(194632, 100000),
                      64'sd1 <<< CFB,
                      coef_round(194632, 100000), -coef_round(94657, 100000) };
    sect_coef[1] = '{ coef_round(6338, 100000), -coef_round(83774, 100000),
                      64'sd1 <<< CFB,
                      coef_round(83774, 100000), -coef_round(6338, 100000) };
    sect_coef[2] = '{ -coef_round(260502, 1000000), coef_round(2569, 100000),
                      64'sd1 <<< CFB,
                      -coef_round(2569, 100000), coef_round(260502, 1000000) };
    sect_coef[3] = '{ coef_round(870686, 1000000), -coef_round(18685, 10000),
                      64'sd1 <<< CFB,
                      coef_round(18685, 10000), -coef_round(870686, 1000000) };

    // Directed: field extremes, then a full-scale Nyquist tone and a full-scale
    // step, which push the sections toward output and history clipping.
    queue_sample(0, 1'b0);
    queue_sample(S_MAX, 1'b0);
    queue_sample(S_MIN, 1'b0);
    queue_sample(-1, 1'b0);
    queue_sample(1, 1'b0);
    for (int i = 0; i < 8; i++) queue_sample((i % 2) ? S_MIN : S_MAX, 1'b0);
    for (int i = 0; i < 6; i++) queue_sample(S_MAX, 1'b0);
    for (int i = 0; i < 3; i++) queue_sample(S_MIN, 1'b0);

    // Random segments of mixed character. The first request of some segments
    // waits until every pair has come back.
    v = 0;
    while (sample_queue.size() < N_RANDOM + 23) begin
      kind    = $urandom_range(0, 5);
      seg_len = $urandom_range(10, 80);
      period  = $urandom_range(1, 40);
      amp     = longint'($urandom_range(4194304, 8388607));
      shift   = $urandom_range(0, 23);
      for (int i = 0; i < seg_len; i++) begin
        r32 = $urandom();
        case (kind)
          0: v = longint'($signed(r32[SB-1:0]));
          // Square wave near full scale, period swept across the band.
          1: v = ((i / period) % 2) ? -amp - (r32[0] ? 1 : 0) : amp;
          2: v = longint'($signed(r32[7:0]));
          3: v = r32[0] ? S_MAX : S_MIN;
          4: v = clamp_bits(v + ((longint'($signed(r32[SB-1:0]))) >>> 6), SB);
          default: v = longint'($signed(r32[SB-1:0])) >>> shift;
        endcase
        queue_sample(v, (i == 0) && ($urandom_range(0, 9) == 0));
      end
    end
    // Make sure at least one full drain happens mid-run.
    sample_queue[23 + 300].drain_first = 1'b1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (sample_queue.size() > 0 || in_ch.valid) @(posedge clk);
    while (pair_queue.size() > 0) @(posedge clk);
    // Allow for a stray extra result after the last expected one.
    repeat (60) @(posedge clk);

    $display("Sent %0d samples (directed extremes, tones, steps, random), checked %0d pairs,",
             samples_sent, pairs_checked);
    $display("%0d predicted outputs clipped to the sample range.", clipped_outputs);
    if (error_count == 0) begin
      $display("tb_iir_allpass_hilbert_pair_unit: done, clean");
    end else begin
      $display("tb_iir_allpass_hilbert_pair_unit: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/iahp_pkg.sv
design/iahp_in_if.sv
design/iahp_out_if.sv
design/iir_allpass_hilbert_pair_unit.sv
dv/tb_iir_allpass_hilbert_pair_unit.sv
